/* hdl/towm_pkg.sv */
// Shared widths, constants and the quarter-wave sine table for the
// three-wheel omni mixer. No dependencies.
package towm_pkg;

   localparam int SINE_FRAC_BITS = 15;
   localparam int MAX_COMMAND    = 100;
   localparam int RAW_FULL_SCALE = 1200;

   localparam int SPEED_W = 7;
   localparam int HEAD_W  = 9;
   localparam int TURN_W  = 8;
   localparam int SCALE_W = 4;
   localparam int DRIVE_W = 13;
   localparam int RAW_W   = SPEED_W + SCALE_W;       // speed * scale
   localparam int TRAW_W  = TURN_W + SCALE_W;        // turn * scale
   localparam int SINE_W  = SINE_FRAC_BITS + 1;      // signed sine entry
   localparam int PROD_W  = RAW_W + SINE_FRAC_BITS + 1;
   localparam int RND_W   = PROD_W - SINE_FRAC_BITS;
   localparam int QIDX_W  = 7;
   localparam int QMAG_W  = SINE_FRAC_BITS + 1;      // quarter entries reach 2^15

   localparam int PIPE_DEPTH = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SPEED_SCALE = 1'b0;          // word index from paddr[2]

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(RAW_FULL_SCALE / MAX_COMMAND);

   localparam int DEG_FULL    = 360;
   localparam int DEG_HALF    = 180;
   localparam int DEG_QUARTER = 90;

   localparam logic [HEAD_W-1:0] WHEEL_BACK        = HEAD_W'(180);
   localparam logic [HEAD_W-1:0] WHEEL_FRONT_RIGHT = HEAD_W'(300);
   localparam logic [HEAD_W-1:0] WHEEL_FRONT_LEFT  = HEAD_W'(60);

   localparam logic [QMAG_W-1:0] SINE_CLAMP = QMAG_W'((1 << SINE_FRAC_BITS) - 1);
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SINE_FRAC_BITS - 1);

   localparam logic [QMAG_W-1:0] QSINE [0:90] = '{
          0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
       5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
      11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
      16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
      21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
      25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
      28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
      30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
      32270, 32365, 32450, 32524, 32588, 32643, 32688, 32723, 32749, 32764,
      32768
   };

   // Command after the first stage, shared by all three wheel lanes.
   typedef struct packed {
      logic [HEAD_W-1:0]        hmod;       // heading reduced below 360
      logic [RAW_W-1:0]         raw_speed;
      logic signed [TRAW_W-1:0] turn_raw;
   } cmd_type;

endpackage

/* hdl/towm_wheel_lane.sv */
// One wheel's datapath: angle difference, sine lookup, product, rounding
// and turn offset, one register stage each. Uses towm_pkg.
module towm_wheel_lane (
   input  logic                                 clock,
   input  logic [towm_pkg::HEAD_W-1:0]          wheel_angle,
   input  towm_pkg::cmd_type                    cmd_ff,
   output logic signed [towm_pkg::DRIVE_W-1:0]  drive_ff
);
   import towm_pkg::*;

   // stage 2: angle difference mod 360
   logic [HEAD_W-1:0]        diff_ff, diff_in;
   logic [HEAD_W:0]          diff_wide;
   logic [RAW_W-1:0]         raw2_ff;
   logic signed [TRAW_W-1:0] tr2_ff;
   // stage 3: sine
   logic signed [SINE_W-1:0] sine_ff, sine_in;
   logic                     s_neg;
   logic [HEAD_W-1:0]        s_half;
   logic [HEAD_W-1:0]        s_fold;
   logic [QMAG_W-1:0]        s_mag, s_clamp;
   logic [QMAG_W:0]          s_wide;
   logic [RAW_W-1:0]         raw3_ff;
   logic signed [TRAW_W-1:0] tr3_ff;
   // stage 4: product
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [RAW_W+SINE_W:0] prod_full;
   logic signed [TRAW_W-1:0] tr4_ff;
   // stage 5: rounded magnitude
   logic [RND_W-1:0]         rnd_ff, rnd_in;
   logic                     rneg_ff;
   logic [PROD_W-1:0]        p_mag, p_sum;
   logic signed [TRAW_W-1:0] tr5_ff;
   // stage 6: signed drive plus turn
   logic signed [DRIVE_W-1:0] drive_in, r_signed;

   always_comb begin
      diff_wide = {1'b0, wheel_angle}
                + ((wheel_angle >= cmd_ff.hmod) ? (HEAD_W+1)'(0) : (HEAD_W+1)'(DEG_FULL))
                - {1'b0, cmd_ff.hmod};
      diff_in = diff_wide[HEAD_W-1:0];
   end

   always_comb begin
      s_neg   = (diff_ff >= HEAD_W'(DEG_HALF));
      s_half  = s_neg ? (diff_ff - HEAD_W'(DEG_HALF)) : diff_ff;
      s_fold  = (s_half > HEAD_W'(DEG_QUARTER)) ? (HEAD_W'(DEG_HALF) - s_half) : s_half;
      s_mag   = QSINE[s_fold[QIDX_W-1:0]];
      s_clamp = (s_mag > SINE_CLAMP) ? SINE_CLAMP : s_mag;
      s_wide  = s_neg ? -{1'b0, s_mag} : {1'b0, s_clamp};
      sine_in = s_wide[SINE_W-1:0];
   end

   always_comb begin
      prod_full = $signed({1'b0, raw3_ff}) * sine_ff;
      prod_in   = prod_full[PROD_W-1:0];
   end

   // round half away from zero on the magnitude
   always_comb begin
      p_mag  = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      p_sum  = p_mag + ROUND_HALF;
      rnd_in = p_sum[SINE_FRAC_BITS +: RND_W];
   end

   always_comb begin
      r_signed = rneg_ff ? -$signed({1'b0, rnd_ff}) : $signed({1'b0, rnd_ff});
      drive_in = r_signed + DRIVE_W'(tr5_ff);
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      raw2_ff  <= cmd_ff.raw_speed;
      tr2_ff   <= cmd_ff.turn_raw;
      sine_ff  <= sine_in;
      raw3_ff  <= raw2_ff;
      tr3_ff   <= tr2_ff;
      prod_ff  <= prod_in;
      tr4_ff   <= tr3_ff;
      rnd_ff   <= rnd_in;
      rneg_ff  <= prod_ff[PROD_W-1];
      tr5_ff   <= tr4_ff;
      drive_ff <= drive_in;
   end

endmodule

/* hdl/three_wheel_omni_mixer_core.sv */
// Top level of the three-wheel omni drive mixer: command stage, three
// wheel lanes, valid pipeline and the speed_scale register. Uses towm_pkg
// and towm_wheel_lane.
//
// Usage:
//  - Commands enter on req_speed / req_heading / req_turn; an item is
//    taken at each rising edge with start high and busy low. busy is tied
//    low: the datapath is a plain pipeline with no feedback.
//  - Throughput: one item per clock, back to back.
//  - An item taken with start high shows rsp_valid and the three drive
//    values at the end of the chain, for that one cycle only. Depth is
//    set by the chain command stage -> angle diff -> sine ROM -> multiply
//    -> rounding -> turn add, one register each.
//  - The receiver cannot stall; results are never held, so the pipeline
//    never stops.
//  - speed_scale sits at byte address 0 of the APB-style csr_ port,
//    written in the access phase; pready is always high. Change it only
//    while no item is in flight.
//  - Synchronous reset empties the valid pipeline and loads speed_scale
//    with 12. Data registers are not reset.
module three_wheel_omni_mixer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [towm_pkg::SPEED_W-1:0]          req_speed,
   input  logic [towm_pkg::HEAD_W-1:0]           req_heading,
   input  logic signed [towm_pkg::TURN_W-1:0]    req_turn,
   output logic                                  rsp_valid,
   output logic signed [towm_pkg::DRIVE_W-1:0]   rsp_back_drive,
   output logic signed [towm_pkg::DRIVE_W-1:0]   rsp_front_right_drive,
   output logic signed [towm_pkg::DRIVE_W-1:0]   rsp_front_left_drive,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [towm_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [towm_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [towm_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import towm_pkg::*;

   logic [SCALE_W-1:0]    scale_ff, scale_in;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   cmd_type               cmd_ff, cmd_in;
   logic                  accept;
   logic                  csr_wr;
   logic                  csr_sel_scale;
   logic signed [TURN_W+SCALE_W:0] turn_full;

   assign busy       = 1'b0;
   assign accept     = start & ~busy;
   assign csr_pready = 1'b1;

   // register file: one word
   assign csr_sel_scale = (csr_paddr[2] == REG_SPEED_SCALE);
   assign csr_wr        = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign scale_in      = (csr_wr && csr_sel_scale) ? csr_pwdata[SCALE_W-1:0] : scale_ff;
   assign csr_prdata    = csr_sel_scale ? CSR_DATA_W'(scale_ff) : '0;

   // stage 1: heading mod 360 (heading < 512 needs one subtract), scaling
   always_comb begin
      cmd_in.hmod      = (req_heading >= HEAD_W'(DEG_FULL))
                         ? (req_heading - HEAD_W'(DEG_FULL)) : req_heading;
      cmd_in.raw_speed = RAW_W'(req_speed) * RAW_W'(scale_ff);
      turn_full        = req_turn * $signed({1'b0, scale_ff});
      cmd_in.turn_raw  = turn_full[TRAW_W-1:0];
   end

   // valid bits ride alongside the data
   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], accept};
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         scale_ff <= SCALE_RESET;
      end else begin
         vld_ff   <= vld_in;
         scale_ff <= scale_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   towm_wheel_lane u_lane_back (
      .clock       (clock),
      .wheel_angle (WHEEL_BACK),
      .cmd_ff      (cmd_ff),
      .drive_ff    (rsp_back_drive)
   );

   towm_wheel_lane u_lane_front_right (
      .clock       (clock),
      .wheel_angle (WHEEL_FRONT_RIGHT),
      .cmd_ff      (cmd_ff),
      .drive_ff    (rsp_front_right_drive)
   );

   towm_wheel_lane u_lane_front_left (
      .clock       (clock),
      .wheel_angle (WHEEL_FRONT_LEFT),
      .cmd_ff      (cmd_ff),
      .drive_ff    (rsp_front_left_drive)
   );

endmodule

/* hdl/towm_checker.sv */
// Port-level checks for three_wheel_omni_mixer_core, attached by bind.
// Uses towm_pkg.
module towm_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic [towm_pkg::SPEED_W-1:0]          req_speed,
   input  logic                                  rsp_valid,
   input  logic signed [towm_pkg::DRIVE_W-1:0]   rsp_back_drive,
   input  logic signed [towm_pkg::DRIVE_W-1:0]   rsp_front_right_drive,
   input  logic signed [towm_pkg::DRIVE_W-1:0]   rsp_front_left_drive
);
   import towm_pkg::*;

   localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = DRIVE_W'(3825);

   // every result traces back to an item accepted at the pipeline's input
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without matching item");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("item lost in pipeline");

   // zero speed leaves only the turn term, equal on all wheels
   a_pure_turn: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_speed == '0) |-> ##PIPE_DEPTH
      (rsp_back_drive == rsp_front_right_drive &&
       rsp_front_right_drive == rsp_front_left_drive))
      else $error("pure turn gave unequal wheels");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (rsp_back_drive >= -DRIVE_LIMIT && rsp_back_drive <= DRIVE_LIMIT &&
       rsp_front_right_drive >= -DRIVE_LIMIT && rsp_front_right_drive <= DRIVE_LIMIT &&
       rsp_front_left_drive >= -DRIVE_LIMIT && rsp_front_left_drive <= DRIVE_LIMIT))
      else $error("drive value out of range");

endmodule

bind three_wheel_omni_mixer_core towm_checker u_towm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .req_speed             (req_speed),
   .rsp_valid             (rsp_valid),
   .rsp_back_drive        (rsp_back_drive),
   .rsp_front_right_drive (rsp_front_right_drive),
   .rsp_front_left_drive  (rsp_front_left_drive)
);
